// ----- rtl/core/lrp_pkg.sv -----
`timescale 1ns / 1ps

package lrp_pkg;

    localparam int CFG_W   = 4;
    localparam int FAULT_W = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    // status gathered while the lookup walks down the chain
    typedef struct packed
    {
        logic hit_found;
        logic empty_found;
    } scan_flags_t;

    // update broadcast to every cell at commit
    typedef struct packed
    {
        logic en;
        logic write;
    } upd_ctl_t;

endpackage

// ----- rtl/core/lrp_cell.sv -----
`timescale 1ns / 1ps

module lrp_cell #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int CELL_IDX  = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [$clog2(FRAMES+1)-1:0]            n_active,
    // scan record from the previous cell
    input  logic                                   scan_in_vld,
    input  lrp_pkg::scan_flags_t                   scan_in_flags,
    input  logic [PAGE_BITS-1:0]                   scan_in_page,
    input  logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_in_hit_idx,
    input  logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_in_hit_rank,
    input  logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_in_empty_idx,
    input  logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_in_best_rank,
    input  logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_in_best_idx,
    input  logic [PAGE_BITS-1:0]                   scan_in_best_page,
    // scan record to the next cell
    output logic                                   scan_out_vld,
    output lrp_pkg::scan_flags_t                   scan_out_flags,
    output logic [PAGE_BITS-1:0]                   scan_out_page,
    output logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_out_hit_idx,
    output logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_out_hit_rank,
    output logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_out_empty_idx,
    output logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_out_best_rank,
    output logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] scan_out_best_idx,
    output logic [PAGE_BITS-1:0]                   scan_out_best_page,
    // commit broadcast
    input  lrp_pkg::upd_ctl_t                      upd,
    input  logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] upd_idx,
    input  logic [$clog2(FRAMES+1)-1:0]            upd_old_rank,
    input  logic [PAGE_BITS-1:0]                   upd_page
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAMES - 1);
    localparam logic             IS_FIRST = (CELL_IDX == 0);

    logic                 valid_reg;
    logic [IDX_W-1:0]     rank_reg;
    logic [PAGE_BITS-1:0] page_reg;

    logic                 vld_reg;
    lrp_pkg::scan_flags_t flags_reg,     flags_next;
    logic [PAGE_BITS-1:0] spage_reg;
    logic [IDX_W-1:0]     hit_idx_reg,   hit_idx_next;
    logic [IDX_W-1:0]     hit_rank_reg,  hit_rank_next;
    logic [IDX_W-1:0]     empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]     best_rank_reg, best_rank_next;
    logic [IDX_W-1:0]     best_idx_reg,  best_idx_next;
    logic [PAGE_BITS-1:0] best_page_reg, best_page_next;

    logic active;

    assign active = (CNT_W'(CELL_IDX) < n_active);

    always_comb
    begin
        flags_next     = scan_in_flags;
        hit_idx_next   = scan_in_hit_idx;
        hit_rank_next  = scan_in_hit_rank;
        empty_idx_next = scan_in_empty_idx;
        best_rank_next = scan_in_best_rank;
        best_idx_next  = scan_in_best_idx;
        best_page_next = scan_in_best_page;
        if (active && valid_reg && (page_reg == scan_in_page) && !scan_in_flags.hit_found)
        begin
            flags_next.hit_found = 1'b1;
            hit_idx_next         = MY_IDX;
            hit_rank_next        = rank_reg;
        end
        if (active && !valid_reg && !scan_in_flags.empty_found)
        begin
            flags_next.empty_found = 1'b1;
            empty_idx_next         = MY_IDX;
        end
        if (active && (IS_FIRST || (rank_reg > scan_in_best_rank)))
        begin
            best_rank_next = rank_reg;
            best_idx_next  = MY_IDX;
            best_page_next = page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= scan_in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_in_vld)
        begin
            flags_reg     <= flags_next;
            spage_reg     <= scan_in_page;
            hit_idx_reg   <= hit_idx_next;
            hit_rank_reg  <= hit_rank_next;
            empty_idx_reg <= empty_idx_next;
            best_rank_reg <= best_rank_next;
            best_idx_reg  <= best_idx_next;
            best_page_reg <= best_page_next;
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (upd.en)
        begin
            if (upd_idx == MY_IDX)
            begin
                rank_reg <= '0;
                if (upd.write)
                begin
                    valid_reg <= 1'b1;
                end
            end
            else if (active && valid_reg && (CNT_W'(rank_reg) < upd_old_rank)
                     && (rank_reg != RANK_MAX))
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.en && upd.write && (upd_idx == MY_IDX))
        begin
            page_reg <= upd_page;
        end
    end

    assign scan_out_vld       = vld_reg;
    assign scan_out_flags     = flags_reg;
    assign scan_out_page      = spage_reg;
    assign scan_out_hit_idx   = hit_idx_reg;
    assign scan_out_hit_rank  = hit_rank_reg;
    assign scan_out_empty_idx = empty_idx_reg;
    assign scan_out_best_rank = best_rank_reg;
    assign scan_out_best_idx  = best_idx_reg;
    assign scan_out_best_page = best_page_reg;

endmodule

// ----- rtl/core/lru_page_replacement.sv -----
`timescale 1ns / 1ps
// lru page replacement, one reference at a time
// flow: a page accepted in idle walks the cell chain one frame per cycle,
//   through a register in each cell, then the fsm enters commit and registers
//   the result; a new reference is taken only after the commit, back in idle;
//   the commit waits while a finished result is held by result_stall
// reset: all frames empty, ranks and fault count zero, frames_in_use = 8

module lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     frames_we,
    input  logic [lrp_pkg::CFG_W-1:0]                frames_in_use,
    input  logic                                     page_valid,
    output logic                                     page_stall,
    input  logic [PAGE_BITS-1:0]                     page_number,
    output logic                                     result_valid,
    input  logic                                     result_stall,
    output logic                                     hit,
    output logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] slot,
    output logic                                     evicted_valid,
    output logic [PAGE_BITS-1:0]                     evicted_page,
    output logic [lrp_pkg::FAULT_W-1:0]              fault_count
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(FRAMES);
    localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);

    logic [lrp_pkg::CFG_W-1:0]   cfg_reg;
    lrp_pkg::state_t             state_reg, state_next;
    logic [lrp_pkg::FAULT_W-1:0] fault_reg;
    logic                        out_vld_reg;
    logic                        hit_reg;
    logic [IDX_W-1:0]            slot_reg;
    logic                        ev_vld_reg;
    logic [PAGE_BITS-1:0]        ev_page_reg;

    logic [CNT_W-1:0] n_active;
    logic             accept;
    logic             commit;

    logic                 ch_vld       [0:FRAMES];
    lrp_pkg::scan_flags_t ch_flags     [0:FRAMES];
    logic [PAGE_BITS-1:0] ch_page      [0:FRAMES];
    logic [IDX_W-1:0]     ch_hit_idx   [0:FRAMES];
    logic [IDX_W-1:0]     ch_hit_rank  [0:FRAMES];
    logic [IDX_W-1:0]     ch_empty_idx [0:FRAMES];
    logic [IDX_W-1:0]     ch_best_rank [0:FRAMES];
    logic [IDX_W-1:0]     ch_best_idx  [0:FRAMES];
    logic [PAGE_BITS-1:0] ch_best_page [0:FRAMES];

    lrp_pkg::upd_ctl_t    upd;
    logic [IDX_W-1:0]     upd_idx;
    logic [CNT_W-1:0]     upd_old_rank;

    lrp_pkg::scan_flags_t fin_flags;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_active = ONE_C;
        end
        else if (32'(cfg_reg) > 32'(FRAMES))
        begin
            n_active = FRAMES_C;
        end
        else
        begin
            n_active = CNT_W'(cfg_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lrp_pkg::CFG_RESET;
        end
        else if (frames_we)
        begin
            cfg_reg <= frames_in_use;
        end
    end

    assign accept     = page_valid && (state_reg == lrp_pkg::ST_IDLE);
    assign page_stall = (state_reg != lrp_pkg::ST_IDLE);
    assign commit     = (state_reg == lrp_pkg::ST_COMMIT) && (!out_vld_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrp_pkg::ST_IDLE:
            begin
                if (page_valid)
                begin
                    state_next = lrp_pkg::ST_SCAN;
                end
            end
            lrp_pkg::ST_SCAN:
            begin
                if (ch_vld[FRAMES])
                begin
                    state_next = lrp_pkg::ST_COMMIT;
                end
            end
            lrp_pkg::ST_COMMIT:
            begin
                if (commit)
                begin
                    state_next = lrp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // head of the chain
    assign ch_vld[0]       = accept;
    assign ch_flags[0]     = '0;
    assign ch_page[0]      = page_number;
    assign ch_hit_idx[0]   = '0;
    assign ch_hit_rank[0]  = '0;
    assign ch_empty_idx[0] = '0;
    assign ch_best_rank[0] = '0;
    assign ch_best_idx[0]  = '0;
    assign ch_best_page[0] = '0;

    for (genvar k = 0; k < FRAMES; k++)
    begin : g_cell
        lrp_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .CELL_IDX  (k)
        ) u_cell (
            .clk                (clk),
            .rst_n              (rst_n),
            .n_active           (n_active),
            .scan_in_vld        (ch_vld[k]),
            .scan_in_flags      (ch_flags[k]),
            .scan_in_page       (ch_page[k]),
            .scan_in_hit_idx    (ch_hit_idx[k]),
            .scan_in_hit_rank   (ch_hit_rank[k]),
            .scan_in_empty_idx  (ch_empty_idx[k]),
            .scan_in_best_rank  (ch_best_rank[k]),
            .scan_in_best_idx   (ch_best_idx[k]),
            .scan_in_best_page  (ch_best_page[k]),
            .scan_out_vld       (ch_vld[k+1]),
            .scan_out_flags     (ch_flags[k+1]),
            .scan_out_page      (ch_page[k+1]),
            .scan_out_hit_idx   (ch_hit_idx[k+1]),
            .scan_out_hit_rank  (ch_hit_rank[k+1]),
            .scan_out_empty_idx (ch_empty_idx[k+1]),
            .scan_out_best_rank (ch_best_rank[k+1]),
            .scan_out_best_idx  (ch_best_idx[k+1]),
            .scan_out_best_page (ch_best_page[k+1]),
            .upd                (upd),
            .upd_idx            (upd_idx),
            .upd_old_rank       (upd_old_rank),
            .upd_page           (ch_page[FRAMES])
        );
    end

    // commit decision from the record at the end of the chain
    assign fin_flags = ch_flags[FRAMES];

    always_comb
    begin
        upd.en = commit;
        if (fin_flags.hit_found)
        begin
            upd.write    = 1'b0;
            upd_idx      = ch_hit_idx[FRAMES];
            upd_old_rank = CNT_W'(ch_hit_rank[FRAMES]);
        end
        else if (fin_flags.empty_found)
        begin
            upd.write    = 1'b1;
            upd_idx      = ch_empty_idx[FRAMES];
            upd_old_rank = FRAMES_C;
        end
        else
        begin
            upd.write    = 1'b1;
            upd_idx      = ch_best_idx[FRAMES];
            upd_old_rank = CNT_W'(ch_best_rank[FRAMES]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                out_vld_reg <= 1'b1;
                if (!fin_flags.hit_found && (fault_reg != lrp_pkg::FAULT_MAX))
                begin
                    fault_reg <= fault_reg + 1'b1;
                end
            end
            else if (!result_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            hit_reg  <= fin_flags.hit_found;
            slot_reg <= upd_idx;
            if (!fin_flags.hit_found && !fin_flags.empty_found)
            begin
                ev_vld_reg  <= 1'b1;
                ev_page_reg <= ch_best_page[FRAMES];
            end
            else
            begin
                ev_vld_reg  <= 1'b0;
                ev_page_reg <= '0;
            end
        end
    end

    assign result_valid  = out_vld_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted_valid = ev_vld_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = fault_reg;

endmodule

// ----- rtl/core/lrp_checker.sv -----
`timescale 1ns / 1ps

module lrp_checker #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     frames_we,
    input logic [lrp_pkg::CFG_W-1:0]                frames_in_use,
    input logic                                     page_valid,
    input logic                                     page_stall,
    input logic [PAGE_BITS-1:0]                     page_number,
    input logic                                     result_valid,
    input logic                                     result_stall,
    input logic                                     hit,
    input logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] slot,
    input logic                                     evicted_valid,
    input logic [PAGE_BITS-1:0]                     evicted_page,
    input logic [lrp_pkg::FAULT_W-1:0]              fault_count
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(hit) && $stable(slot)
            && $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_count))
        else $error("result changed while stalled");

    // one reference in flight at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        page_valid && !page_stall |=> page_stall)
        else $error("page taken while a reference is in flight");

    a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fault_count >= $past(fault_count))
        else $error("fault count went down");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && hit |-> !evicted_valid && (evicted_page == '0))
        else $error("eviction reported on a hit");

endmodule

bind lru_page_replacement lrp_checker #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
) u_lrp_checker (.*);
